[src/utf8v_pkg.sv]
// Shared types and constants for the UTF-8 stream validator.
`timescale 1ns / 1ps
`default_nettype none
package utf8v_pkg;

   localparam int DataWidth = 8;

   // Lead class codes
   localparam logic [1:0] LEAD_OTHER = 2'd0;
   localparam logic [1:0] LEAD_C0    = 2'd1;
   localparam logic [1:0] LEAD_E0    = 2'd2;

   localparam logic [DataWidth-1:0] BYTE_80 = 8'h80;
   localparam logic [DataWidth-1:0] BYTE_C0 = 8'hC0;
   localparam logic [DataWidth-1:0] BYTE_E0 = 8'hE0;

   typedef struct packed {
      logic [1:0] pending;    // continuation bytes still expected
      logic [1:0] lead_class;
      logic       first_80;   // first continuation after E0 was 80
      logic [1:0] cont_idx;   // continuations seen in this sequence
      logic       failed;     // sticky failure for this string
   } seq_state_type;

   localparam seq_state_type SEQ_CLEAR = '{
      pending: 2'd0, lead_class: LEAD_OTHER, first_80: 1'b0,
      cont_idx: 2'd0, failed: 1'b0};

endpackage
`default_nettype wire

[src/utf8v_step.sv]
// Next-state and verdict logic for one byte of the stream.
`timescale 1ns / 1ps
`default_nettype none
module utf8v_step (
   input  wire utf8v_pkg::seq_state_type       cur_state,
   input  wire [utf8v_pkg::DataWidth-1:0]      data_byte,
   input  wire                                 last,
   output utf8v_pkg::seq_state_type            next_state,
   output logic                                verdict
);
   import utf8v_pkg::*;

   seq_state_type upd;
   logic          is_80;
   logic          bad_cont;
   logic [1:0]    pend_dec;

   assign is_80    = (data_byte == BYTE_80);
   assign pend_dec = cur_state.pending - 2'd1;

   always_comb begin
      upd      = cur_state;
      bad_cont = 1'b0;
      if (!cur_state.failed) begin
         if (cur_state.pending == 2'd0) begin
            // lead byte
            if (data_byte[7]) begin
               upd.first_80 = 1'b0;
               upd.cont_idx = 2'd0;
               if (data_byte[7:5] == 3'b110) begin
                  upd.pending    = 2'd1;
                  upd.lead_class = (data_byte == BYTE_C0) ? LEAD_C0 : LEAD_OTHER;
               end else if (data_byte[7:4] == 4'b1110) begin
                  upd.pending    = 2'd2;
                  upd.lead_class = (data_byte == BYTE_E0) ? LEAD_E0 : LEAD_OTHER;
               end else if (data_byte[7:3] == 5'b11110) begin
                  upd.pending    = 2'd3;
                  upd.lead_class = LEAD_OTHER;
               end else begin
                  upd.failed = 1'b1;
               end
            end
         end else begin
            // continuation byte
            if (data_byte[7:6] != 2'b10) begin
               bad_cont = 1'b1;
            end else if (cur_state.lead_class == LEAD_C0 && is_80) begin
               bad_cont = 1'b1;
            end else if (cur_state.lead_class == LEAD_E0) begin
               if (cur_state.cont_idx == 2'd0) begin
                  upd.first_80 = is_80;
               end else if (cur_state.cont_idx == 2'd1 && cur_state.first_80 && is_80) begin
                  bad_cont = 1'b1;
               end
            end
            if (bad_cont) begin
               upd        = SEQ_CLEAR;
               upd.failed = 1'b1;
            end else if (pend_dec == 2'd0) begin
               upd = SEQ_CLEAR;
            end else begin
               upd.pending  = pend_dec;
               upd.cont_idx = cur_state.cont_idx + 2'd1;
            end
         end
      end
   end

   assign verdict    = !upd.failed && (upd.pending == 2'd0);
   assign next_state = last ? SEQ_CLEAR : upd;

endmodule
`default_nettype wire

[src/utf8_stream_validator_core.sv]
// Top level of the UTF-8 stream validator: input register, state, result register.
`timescale 1ns / 1ps
`default_nettype none
// A word accepted into the input register is checked there by the step logic; the verdict for
//   a last word is written into the result register when that register is free.
// Throughput: one word per cycle; a last word waits while the result register is full.
// Reset: synchronous, active high; clears input/result valid and the sequence state.
module utf8_stream_validator_core (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire [utf8v_pkg::DataWidth-1:0]    req_data_byte,
   input  wire                               req_last,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic                              rsp_valid_res
);
   import utf8v_pkg::*;

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic [DataWidth-1:0] in_byte_ff;
   logic                 in_last_ff;

   // sequence state, carried between words of one string
   seq_state_type        state_ff, state_in;

   // result register
   logic                 out_valid_ff, out_valid_in;
   logic                 out_res_ff;

   logic                 out_free;
   logic                 advance;
   logic                 verdict;

   utf8v_step u_step (
      .cur_state  (state_ff),
      .data_byte  (in_byte_ff),
      .last       (in_last_ff),
      .next_state (state_in),
      .verdict    (verdict)
   );

   // A last word needs room in the result register; other words always move.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!in_last_ff || out_free);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = (advance && in_last_ff) || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= SEQ_CLEAR;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last;
      end
      if (advance && in_last_ff) begin
         out_res_ff <= verdict;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_valid_res = out_res_ff;

`ifndef SYNTHESIS
   // a failure always leaves the sequence cleared
   a_fail_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff.failed |-> (state_ff.pending == 2'd0))
      else $error("failed set with pending continuations");

   // no sequence open means no lead facts left over
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff.pending == 2'd0) |-> (state_ff.lead_class == LEAD_OTHER &&
                                      state_ff.cont_idx == 2'd0))
      else $error("stale lead info with no open sequence");

   // the last word of a string resets the state
   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (state_ff == SEQ_CLEAR))
      else $error("state not cleared after last word");

   // a blocked last word stays in the input register
   a_last_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_last_ff && !out_free) |=> (in_valid_ff && in_last_ff))
      else $error("last word dropped under back-pressure");
`endif

endmodule
`default_nettype wire
